// ----- rtl/core/heating_bus_frame_receiver_core_defines.svh -----
// Assertion macros used by the heating bus frame receiver result queue.
`ifndef HEATING_BUS_FRAME_RECEIVER_CORE_DEFINES_SVH
`define HEATING_BUS_FRAME_RECEIVER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define HBFR_ASSERT_NOW(label, cond, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (effect)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define HBFR_ASSERT_NEXT(label, cond, effect, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (effect)) \
		else $error(msg);

`endif

// ----- rtl/core/hbfr_pkg.sv -----
// Package with the types, codes and CRC step of the heating bus frame receiver.
package hbfr_pkg;

	localparam logic [1:0] BUS_BSB = 2'd0;
	localparam logic [1:0] BUS_LPB = 2'd1;
	localparam logic [1:0] BUS_PPS = 2'd2;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_GAP  = 1'b1;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_LENGTH     = 2'd1;
	localparam logic [1:0] ST_CHECKSUM   = 2'd2;
	localparam logic [1:0] ST_INCOMPLETE = 2'd3;

	localparam logic CFG_BUS_KIND        = 1'b0;
	localparam logic CFG_STATION_ADDRESS = 1'b1;

	localparam logic [7:0] MAX_LENGTH_FIELD = 8'd32;

	localparam logic [7:0] BSB_START_A = 8'hDC;
	localparam logic [7:0] BSB_START_B = 8'hDE;
	localparam logic [7:0] LPB_START   = 8'h78;
	localparam logic [7:0] PPS_REQUEST = 8'h17;
	localparam logic [7:0] PPS_START_A = 8'h1D;
	localparam logic [7:0] PPS_START_B = 8'h1E;
	localparam logic [7:0] PPS_WRITE_ADDRESS = 8'h01;

	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int unsigned FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'b01,
		PH_GATHER = 2'b10
	} phase_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] data_byte;
		logic [5:0] position;
		logic [1:0] status;
		logic [5:0] frame_length;
	} item_t;

	typedef struct packed {
		logic  first_valid;
		item_t first;
		logic  second_valid;
		item_t second;
	} step_t;

	function automatic logic [15:0] xmodem_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/hbfr_deframe.sv -----
// Telegram state and per-byte deframing logic with CRC and additive checksum tests.
module hbfr_deframe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic             operation,
	input  logic [7:0]       rx_byte,
	input  logic [1:0]       bus_kind,
	input  logic [7:0]       station_address,
	output hbfr_pkg::step_t  step
);

	hbfr_pkg::phase_t phase_q, phase_d;
	logic [5:0]  byte_count_q, byte_count_d;
	logic [7:0]  length_field_q, length_field_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] sum_q, sum_d;
	logic [15:0] last_two_q, last_two_d;
	logic        long_pps_q, long_pps_d;

	logic        pps;
	logic [7:0]  b;
	logic        is_start;
	logic [3:0]  len_pos;
	logic [5:0]  count_new;
	logic [7:0]  len_new;
	logic [8:0]  target;
	logic [15:0] crc_new;
	logic [15:0] lpb_expect;
	logic [1:0]  end_status;

	always_comb begin
		pps = (bus_kind == hbfr_pkg::BUS_PPS);
		b = pps ? rx_byte : ~rx_byte;
		is_start = ((bus_kind == hbfr_pkg::BUS_BSB)
				&& (b == hbfr_pkg::BSB_START_A || b == hbfr_pkg::BSB_START_B))
			|| ((bus_kind == hbfr_pkg::BUS_LPB) && (b == hbfr_pkg::LPB_START))
			|| (pps && (b == hbfr_pkg::PPS_REQUEST || b == hbfr_pkg::PPS_START_A
				|| b == hbfr_pkg::PPS_START_B));
		if (pps) begin
			len_pos = long_pps_q ? 4'd9 : 4'd8;
		end else if (bus_kind == hbfr_pkg::BUS_LPB) begin
			len_pos = 4'd1;
		end else begin
			len_pos = 4'd3;
		end
		count_new = byte_count_q + 6'd1;
		len_new = (byte_count_q == {2'b00, len_pos}) ? b : length_field_q;
		target = {1'b0, len_new} + {8'd0, (bus_kind == hbfr_pkg::BUS_LPB)};
		crc_new = hbfr_pkg::xmodem_step(crc_q, b);
		// The body sum excludes the two checksum bytes, which are the byte just
		// received and the one before it.
		lpb_expect = {8'(8'd2 - {2'b00, count_new}), 8'h00} + {10'd0, count_new}
			- 16'd3 + sum_q - {8'd0, last_two_q[7:0]};
		if (lpb_expect == {last_two_q[7:0], b}) begin
			end_status = hbfr_pkg::ST_OK;
		end else begin
			end_status = hbfr_pkg::ST_CHECKSUM;
		end
		if (bus_kind != hbfr_pkg::BUS_LPB) begin
			end_status = (crc_new == 16'd0) ? hbfr_pkg::ST_OK : hbfr_pkg::ST_CHECKSUM;
		end

		phase_d = phase_q;
		byte_count_d = byte_count_q;
		length_field_d = length_field_q;
		crc_d = crc_q;
		sum_d = sum_q;
		last_two_d = last_two_q;
		long_pps_d = long_pps_q;
		step = '0;
		step.first.item_kind = hbfr_pkg::KIND_BYTE;
		step.second.item_kind = hbfr_pkg::KIND_END;

		if (step_en) begin
			unique case (phase_q)
				hbfr_pkg::PH_HUNT: begin
					if (operation == hbfr_pkg::OP_BYTE && is_start) begin
						crc_d = hbfr_pkg::xmodem_step(16'd0, b);
						sum_d = {8'd0, b};
						last_two_d = {8'd0, b};
						length_field_d = 8'd0;
						byte_count_d = 6'd1;
						phase_d = hbfr_pkg::PH_GATHER;
						long_pps_d = 1'b0;
						step.first_valid = 1'b1;
						step.first.data_byte = b;
						if (pps && b == hbfr_pkg::PPS_REQUEST) begin
							if (station_address == hbfr_pkg::PPS_WRITE_ADDRESS) begin
								step.second_valid = 1'b1;
								step.second.status = hbfr_pkg::ST_OK;
								step.second.frame_length = 6'd1;
								phase_d = hbfr_pkg::PH_HUNT;
							end else begin
								long_pps_d = 1'b1;
							end
						end
					end
				end
				hbfr_pkg::PH_GATHER: begin
					if (operation == hbfr_pkg::OP_GAP) begin
						step.first_valid = 1'b1;
						step.first.item_kind = hbfr_pkg::KIND_END;
						step.first.status = hbfr_pkg::ST_INCOMPLETE;
						step.first.frame_length = byte_count_q;
						phase_d = hbfr_pkg::PH_HUNT;
						long_pps_d = 1'b0;
					end else begin
						step.first_valid = 1'b1;
						step.first.data_byte = b;
						step.first.position = byte_count_q;
						length_field_d = len_new;
						crc_d = crc_new;
						sum_d = sum_q + {8'd0, b};
						last_two_d = {last_two_q[7:0], b};
						byte_count_d = count_new;
						step.second.frame_length = count_new;
						if (count_new > {2'b00, len_pos}) begin
							priority if (pps) begin
								step.second_valid = 1'b1;
								step.second.status = hbfr_pkg::ST_OK;
							end else if (len_new > hbfr_pkg::MAX_LENGTH_FIELD) begin
								step.second_valid = 1'b1;
								step.second.status = hbfr_pkg::ST_LENGTH;
							end else if ({3'd0, count_new} > target) begin
								step.second_valid = 1'b1;
								step.second.status = hbfr_pkg::ST_LENGTH;
							end else if ({3'd0, count_new} == target) begin
								step.second_valid = 1'b1;
								step.second.status = end_status;
							end else begin
								step.second_valid = 1'b0;
							end
							if (step.second_valid) begin
								phase_d = hbfr_pkg::PH_HUNT;
								long_pps_d = 1'b0;
							end
						end
					end
				end
				default: begin
					phase_d = hbfr_pkg::PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hbfr_pkg::PH_HUNT;
			byte_count_q <= 6'd0;
			length_field_q <= 8'd0;
			crc_q <= 16'd0;
			sum_q <= 16'd0;
			last_two_q <= 16'd0;
			long_pps_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			byte_count_q <= byte_count_d;
			length_field_q <= length_field_d;
			crc_q <= crc_d;
			sum_q <= sum_d;
			last_two_q <= last_two_d;
			long_pps_q <= long_pps_d;
		end
	end

endmodule

// ----- rtl/core/hbfr_out_fifo.sv -----
// Result queue that takes up to two items per cycle and delivers one per beat.
`include "heating_bus_frame_receiver_core_defines.svh"

module hbfr_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  hbfr_pkg::step_t push,
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output hbfr_pkg::item_t head
);

	localparam int unsigned DEPTH = hbfr_pkg::FIFO_DEPTH;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	hbfr_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [1:0]    n_push;
	logic [AW-1:0] wr_ptr_next;

	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	assign pop = out_valid && !out_stall;
	assign room = (count_q <= CW'(DEPTH - 2));
	assign n_push = {1'b0, push.first_valid} + {1'b0, push.second_valid};
	assign wr_ptr_next = wr_ptr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (push.first_valid) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.second_valid) begin
			mem_q[wr_ptr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + AW'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			count_q <= count_q + CW'(n_push) - CW'(pop);
		end
	end

	`HBFR_ASSERT_NOW(a_no_overflow, 1'b1, count_q <= CW'(DEPTH), "Result queue overfilled.")
	`HBFR_ASSERT_NOW(a_second_needs_first, push.second_valid, push.first_valid, "End item pushed without a byte item before it.")
	`HBFR_ASSERT_NOW(a_push_has_room, n_push != 2'd0, count_q <= CW'(DEPTH - 2), "Items pushed into a queue without room for two.")
	`HBFR_ASSERT_NEXT(a_idle_holds, !pop && n_push == 2'd0, $stable(count_q), "Queue fill changed with no push and no pop.")

endmodule

// ----- rtl/core/heating_bus_frame_receiver_core.sv -----
// Top level of the heating bus frame receiver: input register, configuration and result queue.
// A beat is held in the input register, then deframed as it advances into the result queue;
// the input stalls while the four-entry queue lacks room for two results.
// Throughput: one input beat per cycle while each beat yields at most one result and
// out_stall is low; a frame's last beat yields two results, taken one per output beat.
// Reset clears the frame state, both configuration registers and the queue; no clearing pass.
module heating_bus_frame_receiver_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [7:0] data_byte,
	output logic [5:0] position,
	output logic [1:0] status,
	output logic [5:0] frame_length
);

	logic [1:0]      bus_kind_q;
	logic [7:0]      station_address_q;
	logic            valid_s1;
	logic            operation_s1;
	logic [7:0]      rx_byte_s1;
	logic            room;
	logic            advance;
	logic            accept;
	hbfr_pkg::step_t step;
	hbfr_pkg::item_t head;

	assign advance = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_kind_q <= hbfr_pkg::BUS_BSB;
			station_address_q <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				hbfr_pkg::CFG_BUS_KIND:        bus_kind_q <= cfg_data[1:0];
				hbfr_pkg::CFG_STATION_ADDRESS: station_address_q <= cfg_data;
				default:                       bus_kind_q <= bus_kind_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			operation_s1 <= operation;
			rx_byte_s1 <= rx_byte;
		end
	end

	hbfr_deframe u_deframe (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (advance),
		.operation       (operation_s1),
		.rx_byte         (rx_byte_s1),
		.bus_kind        (bus_kind_q),
		.station_address (station_address_q),
		.step            (step)
	);

	hbfr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.head      (head)
	);

	assign item_kind = head.item_kind;
	assign data_byte = head.data_byte;
	assign position = head.position;
	assign status = head.status;
	assign frame_length = head.frame_length;

endmodule
